@@ sv/led_bfs_pkg.sv @@
// shared types, field widths and mode codes for the led blink and flash sequencer
// no dependencies; imported by the core and its port checker
package led_bfs_pkg;

    localparam int LED_COUNT_DEFAULT = 2;

    localparam int LED_ID_W = 2;
    localparam int MODE_W   = 3;
    localparam int TIME_W   = 8;
    localparam int LED_OUT_W = 2;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_SET  = 1'b1;

    localparam logic [MODE_W-1:0] MODE_NONE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ON    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OFF   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BLINK = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLASH = 3'd4;

    // per-lamp state: pending command slot plus the running sequence
    typedef struct packed {
        logic [MODE_W-1:0] pend_mode;
        logic [TIME_W-1:0] pend_on;
        logic [TIME_W-1:0] pend_off;
        logic [TIME_W-1:0] pend_rep;
        logic [MODE_W-1:0] act_mode;
        logic [TIME_W-1:0] act_on;
        logic [TIME_W-1:0] act_off;
        logic [TIME_W-1:0] cycles_left;
        logic [TIME_W-1:0] phase_timer;
        logic              lit;
        logic              in_on;
        logic              hold;
        logic              running;
    } lamp_t;

    // one result beat
    typedef struct packed {
        logic [MODE_W-1:0]    queried_mode;
        logic [LED_OUT_W-1:0] busy_flags;
        logic [LED_OUT_W-1:0] pin_levels;
    } result_t;

endpackage

@@ sv/led_blink_flash_sequencer_core.sv @@
// led blink and flash sequencer: per-lamp command slots, phase timers and a
// two-entry result queue; depends on led_bfs_pkg
// checked by led_bfs_checker, bound in its own file
//
// One beat in, one beat out. A set beat (tuser = 1) stores a pending command
// for the lamp named by led_id; lamps outside the fitted count and modes above
// flash are ignored, and mode none clears the pending command. A tick beat
// (tuser = 0) advances every lamp at once: a lamp with a pending command takes
// it over unless the blink or flash it took over last has not yet spent one
// tick in its off phase, otherwise its blink/flash timers count down. On time
// 0 counts as 256 ticks, off time 0 gives a single flash, repeat 0 runs
// forever. Each beat returns the active-low pin levels and busy flags of
// lamps 0 and 1 and the active mode of the addressed lamp, all taken after
// that beat's update. Every lamp is updated by short logic in the cycle its
// beat is accepted, so the block takes one beat per clock while the queue has
// room. Results sit in a two-entry queue, so a beat is still accepted while
// one result waits; s_tready drops only when two results are waiting. A result
// appears on m_tdata in the cycle after its beat is accepted when no earlier
// result is waiting; otherwise it follows the waiting one. No clearing pass
// follows reset.
module led_blink_flash_sequencer_core #(
    parameter int LED_COUNT = led_bfs_pkg::LED_COUNT_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // slave side: tdata = led_id[1:0], mode[4:2], on_time[12:5],
    // dark_time[20:13], repeat_req[28:21], zero[31:29]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [led_bfs_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser = action (0 tick, 1 set)
    input  logic                               s_tuser,
    // master side: tdata = pin_levels[1:0], busy_flags[3:2],
    // queried_mode[6:4], zero[7]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [led_bfs_pkg::M_TDATA_W-1:0]  m_tdata
);
    import led_bfs_pkg::*;

    // lamps reachable by a led_id and lamps shown on the output fields
    localparam int ADDR_LEDS = (LED_COUNT < (1 << LED_ID_W)) ? LED_COUNT : (1 << LED_ID_W);
    localparam int OUT_LEDS  = (LED_COUNT < LED_OUT_W) ? LED_COUNT : LED_OUT_W;

    // unpacked input beat
    logic [LED_ID_W-1:0] in_led_id;
    logic [MODE_W-1:0]   in_mode;
    logic [TIME_W-1:0]   in_on_time;
    logic [TIME_W-1:0]   in_dark_time;
    logic [TIME_W-1:0]   in_repeat;
    logic                in_fire;

    assign in_led_id    = s_tdata[1:0];
    assign in_mode      = s_tdata[4:2];
    assign in_on_time   = s_tdata[12:5];
    assign in_dark_time = s_tdata[20:13];
    assign in_repeat    = s_tdata[28:21];
    assign in_fire      = s_tvalid && s_tready;

    lamp_t   lamp_reg  [LED_COUNT];
    lamp_t   lamp_next [LED_COUNT];
    result_t result_next;

    // per-lamp update, all lanes side by side
    always_comb begin
        for (int i = 0; i < LED_COUNT; i++) begin
            lamp_next[i] = lamp_reg[i];
            if (s_tuser == ACTION_TICK) begin
                if (lamp_reg[i].pend_mode != MODE_NONE && !lamp_reg[i].hold) begin
                    // take over the pending command
                    lamp_next[i].act_mode    = lamp_reg[i].pend_mode;
                    lamp_next[i].act_on      = lamp_reg[i].pend_on;
                    lamp_next[i].act_off     = lamp_reg[i].pend_off;
                    lamp_next[i].cycles_left = lamp_reg[i].pend_rep;
                    lamp_next[i].pend_mode   = MODE_NONE;
                    if (lamp_reg[i].pend_mode == MODE_ON ||
                        lamp_reg[i].pend_mode == MODE_OFF) begin
                        lamp_next[i].lit         = (lamp_reg[i].pend_mode == MODE_ON);
                        lamp_next[i].phase_timer = '0;
                        lamp_next[i].in_on       = 1'b0;
                        lamp_next[i].hold        = 1'b0;
                        lamp_next[i].running     = 1'b0;
                    end else begin
                        lamp_next[i].lit         = 1'b1;
                        lamp_next[i].phase_timer = lamp_reg[i].pend_on;
                        lamp_next[i].in_on       = 1'b1;
                        lamp_next[i].hold        = 1'b1;
                        lamp_next[i].running     = 1'b1;
                    end
                end else begin
                    if (lamp_reg[i].act_mode == MODE_BLINK ||
                        lamp_reg[i].act_mode == MODE_FLASH) begin
                        lamp_next[i].phase_timer = lamp_reg[i].phase_timer - TIME_W'(1);
                        if (!lamp_reg[i].in_on) begin
                            lamp_next[i].hold = 1'b0;
                        end
                        if (lamp_next[i].phase_timer == '0) begin
                            if (lamp_reg[i].in_on) begin
                                // end of on phase
                                lamp_next[i].lit   = !lamp_reg[i].lit;
                                lamp_next[i].in_on = 1'b0;
                                lamp_next[i].phase_timer = (lamp_reg[i].act_off != '0) ?
                                    lamp_reg[i].act_off : TIME_W'(1);
                            end else begin
                                // end of off phase: count the cycle
                                if (lamp_reg[i].cycles_left != '0) begin
                                    lamp_next[i].cycles_left =
                                        lamp_reg[i].cycles_left - TIME_W'(1);
                                    if (lamp_reg[i].cycles_left == TIME_W'(1)) begin
                                        lamp_next[i].act_mode = MODE_OFF;
                                        lamp_next[i].running  = 1'b0;
                                    end
                                end
                                if (lamp_reg[i].act_off == '0) begin
                                    // single flash done
                                    lamp_next[i].act_mode = MODE_OFF;
                                    lamp_next[i].running  = 1'b0;
                                end else begin
                                    lamp_next[i].lit         = !lamp_reg[i].lit;
                                    lamp_next[i].in_on       = 1'b1;
                                    lamp_next[i].phase_timer = lamp_reg[i].act_on;
                                end
                            end
                        end
                    end
                    // steady modes force the lamp
                    if (lamp_next[i].act_mode == MODE_ON) begin
                        lamp_next[i].lit = 1'b1;
                    end else if (lamp_next[i].act_mode == MODE_OFF) begin
                        lamp_next[i].lit = 1'b0;
                    end
                end
            end
        end
        // set beat: write the pending slot of the addressed lamp
        if (s_tuser == ACTION_SET && in_mode <= MODE_FLASH) begin
            for (int i = 0; i < ADDR_LEDS; i++) begin
                if (in_led_id == LED_ID_W'(i)) begin
                    lamp_next[i].pend_mode = in_mode;
                    lamp_next[i].pend_on   = in_on_time;
                    lamp_next[i].pend_off  = in_dark_time;
                    lamp_next[i].pend_rep  = in_repeat;
                end
            end
        end
    end

    // result fields from the updated state; absent lamps read as zero
    always_comb begin
        result_next = '0;
        for (int i = 0; i < OUT_LEDS; i++) begin
            result_next.pin_levels[i] = !lamp_next[i].lit;
            result_next.busy_flags[i] = (lamp_next[i].pend_mode != MODE_NONE) ||
                                        lamp_next[i].running;
        end
        for (int i = 0; i < ADDR_LEDS; i++) begin
            if (in_led_id == LED_ID_W'(i)) begin
                result_next.queried_mode = lamp_next[i].act_mode;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LED_COUNT; i++) begin
                lamp_reg[i] <= '0;
            end
        end else if (in_fire) begin
            lamp_reg <= lamp_next;
        end
    end

    // two-entry result queue: head drives the master side, tail is the skid slot
    result_t     head_reg;
    result_t     tail_reg;
    logic [1:0]  count_reg;
    logic        out_fire;

    assign out_fire = m_tvalid && m_tready;
    assign s_tready = (count_reg != 2'd2);
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {1'b0, head_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            case (count_reg)
                2'd0: begin
                    if (in_fire) begin
                        count_reg <= 2'd1;
                    end
                end
                2'd1: begin
                    if (in_fire && !out_fire) begin
                        count_reg <= 2'd2;
                    end else if (!in_fire && out_fire) begin
                        count_reg <= 2'd0;
                    end
                end
                2'd2: begin
                    if (out_fire) begin
                        count_reg <= 2'd1;
                    end
                end
                default: begin
                    count_reg <= 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (count_reg == 2'd2) begin
            if (out_fire) begin
                head_reg <= tail_reg;
            end
        end else if (in_fire) begin
            if (count_reg == 2'd0 || out_fire) begin
                head_reg <= result_next;
            end else begin
                tail_reg <= result_next;
            end
        end
    end

endmodule

@@ sv/led_bfs_checker.sv @@
// port-level checks for the led blink and flash sequencer core
// depends on led_bfs_pkg; bound to led_blink_flash_sequencer_core below
module led_bfs_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [led_bfs_pkg::M_TDATA_W-1:0] m_tdata
);
    import led_bfs_pkg::*;

    // a stalled result beat holds its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // pad bit is zero and the reported mode is a defined code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[7] && !(m_tdata[6] && (m_tdata[5] || m_tdata[4])))
        else $error("bad result beat encoding");

    // an accepted beat with nothing queued shows up on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> m_tvalid)
        else $error("result beat missing");

    // backpressure only while results are waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty result queue");

endmodule

bind led_blink_flash_sequencer_core led_bfs_checker u_led_bfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
